@@ design/bsrf_pkg.sv @@
// ----------------------------------------------------------------------------
// Byte stream ring FIFO package
// Shared command and status codes, field widths and the result word type.
// ----------------------------------------------------------------------------
package bsrf_pkg;

   localparam int CMD_W    = 3;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int LEVEL_W  = 11;
   localparam int CAP_W    = 11;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_START  = 3'd2,
      CMD_FINISH = 3'd3,
      CMD_STOP   = 3'd4,
      CMD_RESET  = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 3'd0,
      ST_EMPTY  = 3'd1,
      ST_FULL   = 3'd2,
      ST_EOS    = 3'd3,
      ST_ABORT  = 3'd4,
      ST_NOTRUN = 3'd5
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   pop_byte;
      logic [STATUS_W-1:0] status;
      logic [LEVEL_W-1:0]  level;
   } rsp_word_type;

endpackage

@@ design/bsrf_channels.sv @@
// ----------------------------------------------------------------------------
// Byte stream ring FIFO channels
// Valid/ready channel interfaces for commands, results and the capacity write.
// ----------------------------------------------------------------------------
interface bsrf_req_if;
   logic                          valid;
   logic                          ready;
   logic [bsrf_pkg::CMD_W-1:0]    cmd;
   logic [bsrf_pkg::BYTE_W-1:0]   push_byte;

   modport source (output valid, output cmd, output push_byte, input ready);
   modport sink   (input valid, input cmd, input push_byte, output ready);
endinterface

interface bsrf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bsrf_pkg::BYTE_W-1:0]   pop_byte;
   logic [bsrf_pkg::STATUS_W-1:0] status;
   logic [bsrf_pkg::LEVEL_W-1:0]  level;

   modport source (output valid, output pop_byte, output status, output level,
                   input ready);
   modport sink   (input valid, input pop_byte, input status, input level,
                   output ready);
endinterface

interface bsrf_csr_if;
   logic                        valid;
   logic                        ready;
   logic [bsrf_pkg::CAP_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ design/byte_stream_ring_fifo_top.sv @@
// ----------------------------------------------------------------------------
// Byte stream ring FIFO
// Ring byte store with push, pop, start, finish, stop and reset commands.
//
//   Port     Direction  Word
//   req_ch   in         cmd, push_byte
//   rsp_ch   out        pop_byte, status, level (one per command)
//   csr_ch   in         capacity, 11 bits, always ready
//
// One command is taken per cycle while req_ch.ready is high; its result passes
// through the s1 registers and then the result buffer. The byte store is a
// single memory with one write and one registered read port; the read issued by a pop is returned by the next cycle.
// A three-word result buffer lets commands flow on while results stall, until it fills.
// Reset is synchronous; the byte store itself is not cleared.
// ----------------------------------------------------------------------------
module byte_stream_ring_fifo_top #(
   parameter int DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   bsrf_req_if.sink    req_ch,
   bsrf_rsp_if.source  rsp_ch,
   bsrf_csr_if.sink    csr_ch
);
   import bsrf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = (PTR_W + 1 > CAP_W) ? PTR_W + 1 : CAP_W;
   localparam int OB_DEPTH = 3;
   localparam int OB_W = 2;

   logic [CMP_W-1:0]   cap_ff;
   logic [CMP_W-1:0]   cap_wr;

   logic [PTR_W-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [CMP_W-1:0]   count_ff, count_in;
   logic               run_ff, run_in, stop_ff, stop_in, fin_ff, fin_in;

   logic [CMP_W-1:0]   wp_inc, rp_inc;
   logic               accept, wr_en, rd_en;
   logic [STATUS_W-1:0] status_in;

   logic [BYTE_W-1:0]  mem [DEPTH];
   logic [BYTE_W-1:0]  rd_ff;

   logic               s1_valid_ff;
   logic               s1_take_ff;
   logic [STATUS_W-1:0] s1_status_ff;
   logic [LEVEL_W-1:0] s1_level_ff;

   rsp_word_type       ob_data_ff [OB_DEPTH];
   rsp_word_type       ob_word;
   logic [OB_W-1:0]    ob_head_ff, ob_tail_ff, ob_cnt_ff;
   logic               deq;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cap_wr = CMP_W'(csr_ch.data);
      if (cap_wr == '0) begin
         cap_wr = CMP_W'(1);
      end else if (cap_wr > CMP_W'(DEPTH)) begin
         cap_wr = CMP_W'(DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CMP_W'(DEPTH);
      end else if (csr_ch.valid) begin
         cap_ff <= cap_wr;
      end
   end

   assign req_ch.ready = ({1'b0, ob_cnt_ff} + {{OB_W{1'b0}}, s1_valid_ff})
                         < (OB_W + 1)'(OB_DEPTH);
   assign accept = req_ch.valid && req_ch.ready;

   assign wp_inc = CMP_W'(wp_ff) + CMP_W'(1);
   assign rp_inc = CMP_W'(rp_ff) + CMP_W'(1);

   always_comb begin
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      count_in  = count_ff;
      run_in    = run_ff;
      stop_in   = stop_ff;
      fin_in    = fin_ff;
      status_in = ST_OK;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      if (accept) begin
         case (req_ch.cmd)
            CMD_PUSH: begin
               if (!run_ff) begin
                  status_in = ST_NOTRUN;
               end else if (stop_ff) begin
                  status_in = ST_ABORT;
               end else if (count_ff >= cap_ff) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wp_in    = (wp_inc >= cap_ff) ? '0 : wp_inc[PTR_W-1:0];
                  count_in = count_ff + CMP_W'(1);
               end
            end
            CMD_POP: begin
               if (stop_ff) begin
                  status_in = ST_ABORT;
               end else if (count_ff != '0) begin
                  rd_en    = 1'b1;
                  rp_in    = (rp_inc >= cap_ff) ? '0 : rp_inc[PTR_W-1:0];
                  count_in = count_ff - CMP_W'(1);
               end else if (fin_ff) begin
                  fin_in    = 1'b0;
                  status_in = ST_EOS;
               end else begin
                  status_in = ST_EMPTY;
               end
            end
            CMD_START: begin
               wp_in    = '0;
               rp_in    = '0;
               count_in = '0;
               run_in   = 1'b1;
               stop_in  = 1'b0;
               fin_in   = 1'b0;
            end
            CMD_FINISH: begin
               fin_in = 1'b1;
            end
            CMD_STOP: begin
               stop_in = 1'b1;
            end
            CMD_RESET: begin
               wp_in    = '0;
               rp_in    = '0;
               count_in = '0;
               run_in   = 1'b0;
               stop_in  = 1'b0;
               fin_in   = 1'b0;
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         rp_ff       <= '0;
         count_ff    <= '0;
         run_ff      <= 1'b0;
         stop_ff     <= 1'b0;
         fin_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         count_ff    <= count_in;
         run_ff      <= run_in;
         stop_ff     <= stop_in;
         fin_ff      <= fin_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_take_ff   <= rd_en;
         s1_status_ff <= status_in;
         s1_level_ff  <= count_in[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= req_ch.push_byte;
      end
      if (rd_en) begin
         rd_ff <= mem[rp_ff];
      end
   end

   assign ob_word.pop_byte = s1_take_ff ? rd_ff : '0;
   assign ob_word.status   = s1_status_ff;
   assign ob_word.level    = s1_level_ff;

   assign deq = (ob_cnt_ff != '0) && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         ob_data_ff[ob_tail_ff] <= ob_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_head_ff <= '0;
         ob_tail_ff <= '0;
         ob_cnt_ff  <= '0;
      end else begin
         if (s1_valid_ff) begin
            ob_tail_ff <= (ob_tail_ff == OB_W'(OB_DEPTH - 1)) ? '0
                          : ob_tail_ff + OB_W'(1);
         end
         if (deq) begin
            ob_head_ff <= (ob_head_ff == OB_W'(OB_DEPTH - 1)) ? '0
                          : ob_head_ff + OB_W'(1);
         end
         if (s1_valid_ff && !deq) begin
            ob_cnt_ff <= ob_cnt_ff + OB_W'(1);
         end else if (!s1_valid_ff && deq) begin
            ob_cnt_ff <= ob_cnt_ff - OB_W'(1);
         end
      end
   end

   assign rsp_ch.valid    = (ob_cnt_ff != '0);
   assign rsp_ch.pop_byte = ob_data_ff[ob_head_ff].pop_byte;
   assign rsp_ch.status   = ob_data_ff[ob_head_ff].status;
   assign rsp_ch.level    = ob_data_ff[ob_head_ff].level;

endmodule
